// ===== hw/rtl/cbc_pkg.sv =====
`default_nettype none

package cbc_pkg;

    // Store geometry
    localparam int KEY_DEPTH = 64;
    localparam int MSG_DEPTH = 64;
    localparam int TBL_DEPTH = 52;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int MSG_AW    = $clog2(MSG_DEPTH);
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CNT_W     = $clog2(MSG_DEPTH + 1);
    localparam int LEN_W     = 7;
    localparam int CFG_AW    = 3;

    // Input item modes
    localparam logic [1:0] MODE_LOAD_KEY = 2'd0;
    localparam logic [1:0] MODE_LOAD_SUB = 2'd1;
    localparam logic [1:0] MODE_ENCIPHER = 2'd2;
    localparam logic [1:0] MODE_DECIPHER = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_REVERSE    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ROTATE     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SUBSTITUTE = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_XOR        = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_ROT_AMOUNT = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_KEY_LENGTH = 3'd5;

    // Character codes
    localparam logic [7:0] ROT_LO   = 8'd48;
    localparam logic [7:0] ROT_HI   = 8'd122;
    localparam logic [6:0] ROT_SPAN = 7'd75;
    localparam logic [7:0] LOWER_A  = 8'd97;
    localparam logic [7:0] LOWER_Z  = 8'd122;
    localparam logic [7:0] UPPER_A  = 8'd65;
    localparam logic [7:0] UPPER_Z  = 8'd90;
    localparam logic [7:0] CASE_LEN = 8'd26;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] slot;
        logic [7:0]        letter;
    } sub_load_t;

    typedef struct packed {
        logic              en;
        logic              inverse;
        logic [TBL_AW-1:0] index;
    } sub_lookup_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= LOWER_A && c <= LOWER_Z) || (c >= UPPER_A && c <= UPPER_Z);
    endfunction

    // a..z -> 0..25, A..Z -> 26..51, anything else -> 0
    function automatic logic [TBL_AW-1:0] letter_index(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            d = c - LOWER_A;
        end
        else if (c >= UPPER_A && c <= UPPER_Z) begin
            d = c - UPPER_A + CASE_LEN;
        end
        return d[TBL_AW-1:0];
    endfunction

    function automatic logic [7:0] letter_of(input logic [TBL_AW-1:0] idx);
        logic [7:0] d;
        d = 8'(idx);
        return (d < CASE_LEN) ? (LOWER_A + d) : (UPPER_A + d - CASE_LEN);
    endfunction

    // Rotate codes 48..122 by r (r below 75); other codes pass
    function automatic logic [7:0] rotate_code(input logic [7:0] c, input logic [6:0] r);
        logic [7:0] t;
        t = (c - ROT_LO) + {1'b0, r};
        if (t >= {1'b0, ROT_SPAN}) begin
            t = t - {1'b0, ROT_SPAN};
        end
        return (c < ROT_LO || c > ROT_HI) ? c : (ROT_LO + t);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cbc_subst.sv =====
`default_nettype none

// Forward and inverse letter substitution tables with registered reads.
module cbc_subst (
    input  logic                 clk,
    input  cbc_pkg::sub_load_t   load,
    input  cbc_pkg::sub_lookup_t lookup,
    output logic [7:0]           data
);
    import cbc_pkg::*;

    logic [7:0] fwd_mem [TBL_DEPTH];
    logic [7:0] inv_mem [TBL_DEPTH];
    logic [7:0] fwd_q_reg;
    logic [7:0] inv_q_reg;
    logic       inv_sel_reg;
    logic       fwd_we;
    logic       inv_we;

    // Drop loads to slots past the last letter
    assign fwd_we = load.en && (load.slot < TBL_AW'(TBL_DEPTH));
    assign inv_we = fwd_we && is_letter(load.letter);

    always_ff @(posedge clk)
    begin
        if (fwd_we)
        begin
            fwd_mem[load.slot] <= load.letter;
        end
        if (lookup.en && !lookup.inverse)
        begin
            fwd_q_reg <= fwd_mem[lookup.index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
        begin
            inv_mem[letter_index(load.letter)] <= letter_of(load.slot);
        end
        if (lookup.en && lookup.inverse)
        begin
            inv_q_reg <= inv_mem[lookup.index];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup.en)
        begin
            inv_sel_reg <= lookup.inverse;
        end
    end

    assign data = inv_sel_reg ? inv_q_reg : fwd_q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cascaded_byte_cipher.sv =====
`default_nettype none

// Byte cipher cascade. Each input beat either loads a key byte (mode 0), loads a
// substitution entry (mode 1), or carries a message byte to encipher (mode 2) or
// decipher (mode 3). Enciphering runs reversal, rotation within codes 48..122,
// letter substitution and repeating-key XOR in that order; deciphering runs the
// inverses in the opposite order. Loads finish in the accepting cycle and give no
// result. With reversal off a message byte goes through S_MOD, which reduces the
// current key position by the key length until it lies below it, then S_A, S_B
// and, when deciphering, S_C before its result loads the output register; the
// chained registered reads of the key store and substitution tables set this
// order. With reversal on, each byte is buffered on acceptance and the last byte
// starts a readout pass: S_MOD first reduces the starting key position (n-1 when
// deciphering, 0 when enciphering), then each byte goes through S_FETCH, S_A, S_B
// and, when deciphering, S_C, n being the number of buffered bytes (at most 64).
// Bytes past 64 are dropped and the reversed message carries overflow on every
// beat. An output register holds each result until taken; processing stalls
// while it is full. Configuration writes are always accepted (cfg_ready is tied
// high) and should only happen while no message is in flight. Key and table
// entries read before being loaded return unspecified data.
module cascaded_byte_cipher (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [5:0]                 slot,
    input  logic [7:0]                 byte_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 byte_out,
    output logic                       last_out,
    output logic                       overflow,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cbc_pkg::CFG_AW-1:0] cfg_index,
    input  logic [6:0]                 cfg_data
);
    import cbc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_A     = 3'd3;
    localparam logic [2:0] S_B     = 3'd4;
    localparam logic [2:0] S_C     = 3'd5;

    // Configuration
    logic             rev_en_reg;
    logic             rot_en_reg;
    logic             sub_en_reg;
    logic             xor_en_reg;
    logic [6:0]       rot_amt_reg;
    logic [LEN_W-1:0] key_len_reg;

    // Message state
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [KEY_AW-1:0] key_pos_reg, key_pos_next;
    logic              dropped_reg, dropped_next;

    // Working registers of the current pass
    logic              dec_reg, dec_next;
    logic              last_reg, last_next;
    logic              rev_pass_reg, rev_pass_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        byte_reg, byte_next;
    logic [7:0]        work_reg, work_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [MSG_AW-1:0] j_reg, j_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_out_reg, byte_out_next;
    logic       last_out_reg, last_out_next;
    logic       overflow_reg, overflow_next;

    // Memories
    logic [7:0] key_mem [KEY_DEPTH];
    logic [7:0] buf_mem [MSG_DEPTH];
    logic [7:0] key_q_reg;
    logic [7:0] buf_q_reg;

    logic              in_fire;
    logic              cfg_fire;
    logic              is_msg;
    logic              key_we;
    logic              buf_we;
    logic              key_re;
    logic              buf_re;
    logic [LEN_W-1:0]  kl;
    logic              xor_on;
    logic [6:0]        r_enc;
    logic [6:0]        r_dec;
    logic [7:0]        cur_byte;
    logic [7:0]        enc_rot;
    logic [7:0]        xor_val;
    logic [7:0]        sub_val;
    logic [7:0]        sub_data;
    logic [7:0]        enc_result;
    logic [7:0]        dec_result;
    logic              can_load;
    logic              out_load;
    logic              msg_end;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  n_minus_1;
    sub_load_t         sub_load;
    sub_lookup_t       sub_lookup;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign is_msg    = (mode == MODE_ENCIPHER) || (mode == MODE_DECIPHER);

    // Key length in use saturates at the key store depth
    assign kl     = (key_len_reg > LEN_W'(KEY_DEPTH)) ? LEN_W'(KEY_DEPTH) : key_len_reg;
    assign xor_on = xor_en_reg && (kl != '0);
    assign r_enc  = (rot_amt_reg >= ROT_SPAN) ? (rot_amt_reg - ROT_SPAN) : rot_amt_reg;
    assign r_dec  = (r_enc == 7'd0) ? 7'd0 : (ROT_SPAN - r_enc);

    // Datapath
    assign cur_byte   = rev_pass_reg ? buf_q_reg : byte_reg;
    assign enc_rot    = rot_en_reg ? rotate_code(cur_byte, r_enc) : cur_byte;
    assign xor_val    = xor_on ? (work_reg ^ key_q_reg) : work_reg;
    assign sub_val    = (sub_en_reg && is_letter(work_reg)) ? sub_data : work_reg;
    assign enc_result = xor_on ? (sub_val ^ key_q_reg) : sub_val;
    assign dec_result = rot_en_reg ? rotate_code(sub_val, r_dec) : sub_val;

    // Store writes on load beats and buffered message beats
    assign key_we = in_fire && (mode == MODE_LOAD_KEY) && ({1'b0, slot} < LEN_W'(KEY_DEPTH));
    assign buf_we = in_fire && is_msg && rev_en_reg && (byte_count_reg < CNT_W'(MSG_DEPTH));
    assign key_re = (state_reg == S_A);
    assign buf_re = (state_reg == S_FETCH);

    assign sub_load.en     = in_fire && (mode == MODE_LOAD_SUB);
    assign sub_load.slot   = slot;
    assign sub_load.letter = byte_in;

    always_comb
    begin
        sub_lookup.en      = 1'b0;
        sub_lookup.inverse = 1'b0;
        sub_lookup.index   = letter_index(enc_rot);
        if (state_reg == S_A && !dec_reg)
        begin
            sub_lookup.en = 1'b1;
        end
        else if (state_reg == S_B && dec_reg)
        begin
            sub_lookup.en      = 1'b1;
            sub_lookup.inverse = 1'b1;
            sub_lookup.index   = letter_index(xor_val);
        end
    end

    cbc_subst u_subst (
        .clk    (clk),
        .load   (sub_load),
        .lookup (sub_lookup),
        .data   (sub_data)
    );

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[slot[KEY_AW-1:0]] <= byte_in;
        end
        if (key_re)
        begin
            key_q_reg <= key_mem[rem_reg[KEY_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[byte_count_reg[MSG_AW-1:0]] <= byte_in;
        end
        if (buf_re)
        begin
            buf_q_reg <= buf_mem[j_reg];
        end
    end

    assign count_inc = buf_we ? (byte_count_reg + CNT_W'(1)) : byte_count_reg;
    assign n_minus_1 = count_inc - CNT_W'(1);
    assign can_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        key_pos_next    = key_pos_reg;
        dropped_next    = dropped_reg;
        dec_next        = dec_reg;
        last_next       = last_reg;
        rev_pass_next   = rev_pass_reg;
        ovf_next        = ovf_reg;
        byte_next       = byte_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        j_next          = j_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        byte_out_next   = byte_out_reg;
        last_out_next   = last_out_reg;
        overflow_next   = overflow_reg;
        out_load        = 1'b0;
        msg_end         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && is_msg)
                begin
                    dec_next = (mode == MODE_DECIPHER);
                    if (rev_en_reg)
                    begin
                        // Buffer the beat, or drop it once the buffer is full
                        byte_count_next = count_inc;
                        if (!buf_we)
                        begin
                            dropped_next = 1'b1;
                        end
                        if (last_in)
                        begin
                            rev_pass_next = 1'b1;
                            ovf_next      = !buf_we || dropped_reg;
                            j_next        = n_minus_1[MSG_AW-1:0];
                            rem_next      = (mode == MODE_DECIPHER) ? LEN_W'(n_minus_1) : '0;
                            state_next    = S_MOD;
                        end
                    end
                    else
                    begin
                        rev_pass_next = 1'b0;
                        ovf_next      = 1'b0;
                        byte_next     = byte_in;
                        last_next     = last_in;
                        rem_next      = LEN_W'(key_pos_reg);
                        state_next    = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                // Reduce the key position below the key length
                if (kl != '0 && rem_reg >= kl)
                begin
                    rem_next = rem_reg - kl;
                end
                else
                begin
                    state_next = rev_pass_reg ? S_FETCH : S_A;
                end
            end
            S_FETCH:
            begin
                state_next = S_A;
            end
            S_A:
            begin
                work_next  = dec_reg ? cur_byte : enc_rot;
                state_next = S_B;
            end
            S_B:
            begin
                if (dec_reg)
                begin
                    work_next  = xor_val;
                    state_next = S_C;
                end
                else
                begin
                    out_load      = can_load;
                    byte_out_next = can_load ? enc_result : byte_out_reg;
                end
            end
            S_C:
            begin
                out_load      = can_load;
                byte_out_next = can_load ? dec_result : byte_out_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            last_out_next  = rev_pass_reg ? (j_reg == '0) : last_reg;
            overflow_next  = rev_pass_reg && ovf_reg;
            if (rev_pass_reg && j_reg != '0)
            begin
                // Advance to the next byte in reversed order
                j_next     = j_reg - MSG_AW'(1);
                state_next = S_FETCH;
                if (dec_reg)
                begin
                    rem_next = (rem_reg == '0) ? (kl - LEN_W'(1)) : (rem_reg - LEN_W'(1));
                end
                else
                begin
                    rem_next = (rem_reg + LEN_W'(1) == kl) ? '0 : (rem_reg + LEN_W'(1));
                end
            end
            else
            begin
                state_next = S_IDLE;
                if (kl == '0 || rem_reg + LEN_W'(1) == kl)
                begin
                    key_pos_next = '0;
                end
                else
                begin
                    key_pos_next = KEY_AW'(rem_reg + LEN_W'(1));
                end
                if (rev_pass_reg || last_reg)
                begin
                    msg_end         = 1'b1;
                    byte_count_next = '0;
                    dropped_next    = 1'b0;
                    key_pos_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            byte_count_reg <= '0;
            key_pos_reg    <= '0;
            dropped_reg    <= 1'b0;
            dec_reg        <= 1'b0;
            last_reg       <= 1'b0;
            rev_pass_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            rem_reg        <= '0;
            j_reg          <= '0;
            out_valid_reg  <= 1'b0;
            last_out_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            key_pos_reg    <= key_pos_next;
            dropped_reg    <= dropped_next;
            dec_reg        <= dec_next;
            last_reg       <= last_next;
            rev_pass_reg   <= rev_pass_next;
            ovf_reg        <= ovf_next;
            rem_reg        <= rem_next;
            j_reg          <= j_next;
            out_valid_reg  <= out_valid_next;
            last_out_reg   <= last_out_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Payload registers hold data only
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        work_reg     <= work_next;
        byte_out_reg <= byte_out_next;
    end

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_en_reg  <= 1'b0;
            rot_en_reg  <= 1'b0;
            sub_en_reg  <= 1'b0;
            xor_en_reg  <= 1'b0;
            rot_amt_reg <= '0;
            key_len_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_REVERSE:    rev_en_reg  <= cfg_data[0];
                CFG_ROTATE:     rot_en_reg  <= cfg_data[0];
                CFG_SUBSTITUTE: sub_en_reg  <= cfg_data[0];
                CFG_XOR:        xor_en_reg  <= cfg_data[0];
                CFG_ROT_AMOUNT: rot_amt_reg <= cfg_data;
                CFG_KEY_LENGTH: key_len_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = byte_out_reg;
    assign last_out  = last_out_reg;
    assign overflow  = overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(MSG_DEPTH))
        else $error("byte count past buffer depth");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        msg_end |=> (byte_count_reg == '0 && !dropped_reg && key_pos_reg == '0))
        else $error("message state not cleared at end of message");

    a_key_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A) |-> (kl == '0 || rem_reg < kl))
        else $error("key position not reduced before key read");

    a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (rev_pass_reg && CNT_W'(j_reg) < byte_count_reg))
        else $error("reversed readout outside buffered bytes");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the byte cipher cascade. A scoreboard class keeps its
// own copy of the registers, the key store, both substitution maps and the
// reversal buffer, and turns every accepted input beat into the output beats it
// must cause. One monitor samples the handshakes at the rising edge; tasks send
// input beats with random gaps and config writes; the receiver stalls randomly.
module testbench;
    import cbc_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int DRAIN_LIMIT   = 50_000;
    // Worst quiet time after the last result: a key position reduction after
    // a key length change plus the byte pipeline.
    localparam int SETTLE_CYCLES = 100;
    localparam int ITEM_TARGET   = 170;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_AW-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] value;
        logic       tail;
        logic       dropped;
    } cipher_beat_t;

    class cipher_scoreboard;
        bit           rev_on, rot_on, sub_on, xor_on;
        bit [6:0]     rot_dist, key_len;
        bit [7:0]     key_bytes [KEY_DEPTH];
        bit [7:0]     fwd_map [TBL_DEPTH];
        bit [7:0]     inv_map [TBL_DEPTH];
        bit [7:0]     held [$];
        bit           lost;
        int           key_pos;
        cipher_beat_t expected_beats [$];
        int           errors, beats_checked, messages_closed, lossy_beats;

        function int code_index(bit [7:0] c);
            if (c >= LOWER_A && c <= LOWER_Z)
                return int'(c) - int'(LOWER_A);
            if (c >= UPPER_A && c <= UPPER_Z)
                return int'(c) - int'(UPPER_A) + int'(CASE_LEN);
            return -1;
        endfunction

        function bit [7:0] index_code(int idx);
            if (idx < int'(CASE_LEN))
                return 8'(int'(LOWER_A) + idx);
            return 8'(int'(UPPER_A) + idx - int'(CASE_LEN));
        endfunction

        function bit [7:0] shift(bit [7:0] c, int r);
            if (c < ROT_LO || c > ROT_HI)
                return c;
            return 8'(int'(ROT_LO) + (int'(c) - int'(ROT_LO) + r) % int'(ROT_SPAN));
        endfunction

        function int active_len();
            return (key_len > KEY_DEPTH) ? KEY_DEPTH : int'(key_len);
        endfunction

        function bit [7:0] mix(bit [7:0] c, int pos);
            int kl;
            kl = active_len();
            if (!xor_on || kl == 0)
                return c;
            return c ^ key_bytes[pos % kl];
        endfunction

        function bit [7:0] encipher(bit [7:0] c, int pos);
            int li;
            if (rot_on)
                c = shift(c, rot_dist % int'(ROT_SPAN));
            if (sub_on) begin
                li = code_index(c);
                if (li >= 0)
                    c = fwd_map[li];
            end
            return mix(c, pos);
        endfunction

        function bit [7:0] decipher(bit [7:0] c, int pos);
            int li;
            c = mix(c, pos);
            if (sub_on) begin
                li = code_index(c);
                if (li >= 0)
                    c = inv_map[li];
            end
            if (rot_on)
                c = shift(c, (int'(ROT_SPAN) - rot_dist % int'(ROT_SPAN)) % int'(ROT_SPAN));
            return c;
        endfunction

        function void close_message();
            held.delete();
            lost = 1'b0;
            key_pos = 0;
            messages_closed++;
        endfunction

        function void note_config(logic [CFG_AW-1:0] idx, logic [6:0] d);
            case (idx)
                CFG_REVERSE:    rev_on = d[0];
                CFG_ROTATE:     rot_on = d[0];
                CFG_SUBSTITUTE: sub_on = d[0];
                CFG_XOR:        xor_on = d[0];
                CFG_ROT_AMOUNT: rot_dist = d;
                CFG_KEY_LENGTH: key_len = d;
                default: ;
            endcase
        endfunction

        function void note_input(logic [1:0] m, logic [5:0] s, logic [7:0] b, logic l);
            cipher_beat_t beat;
            bit           dec;
            int           li, n, j, kl;
            dec = (m == MODE_DECIPHER);
            case (m)
                MODE_LOAD_KEY: key_bytes[s] = b;
                MODE_LOAD_SUB: begin
                    if (s < TBL_DEPTH) begin
                        fwd_map[s] = b;
                        li = code_index(b);
                        if (li >= 0)
                            inv_map[li] = index_code(int'(s));
                    end
                end
                default: begin
                    if (!rev_on) begin
                        beat.value   = dec ? decipher(b, key_pos) : encipher(b, key_pos);
                        beat.tail    = l;
                        beat.dropped = 1'b0;
                        expected_beats.insert(expected_beats.size(), beat);
                        kl = active_len();
                        key_pos = (kl == 0) ? 0 : (key_pos + 1) % kl;
                        if (l)
                            close_message();
                    end
                    else begin
                        if (held.size() < MSG_DEPTH)
                            held.insert(held.size(), b);
                        else
                            lost = 1'b1;
                        if (l) begin
                            n = held.size();
                            for (int k = 0; k < n; k++) begin
                                j = n - 1 - k;
                                beat.value   = dec ? decipher(held[j], j)
                                                   : encipher(held[j], k);
                                beat.tail    = (k == n - 1);
                                beat.dropped = lost;
                                expected_beats.insert(expected_beats.size(), beat);
                            end
                            close_message();
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] b, logic l, logic o);
            cipher_beat_t want;
            beats_checked++;
            if (o === 1'b1)
                lossy_beats++;
            if (expected_beats.size() == 0) begin
                $error("result with nothing expected: byte_out %0d last_out %0b overflow %0b",
                       b, l, o);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (b !== want.value) begin
                $error("byte_out: expected %0d, got %0d", want.value, b);
                errors++;
            end
            if (l !== want.tail) begin
                $error("last_out: expected %0b, got %0b", want.tail, l);
                errors++;
            end
            if (o !== want.dropped) begin
                $error("overflow: expected %0b, got %0b", want.dropped, o);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        mode      = MODE_LOAD_KEY;
    logic [5:0]        slot      = '0;
    logic [7:0]        byte_in   = '0;
    logic              last_in   = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        byte_out;
    logic              last_out;
    logic              overflow;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_index = CFG_REVERSE;
    logic [6:0]        cfg_data  = '0;

    cipher_scoreboard sb = new;

    int cycle_count      = 0;
    int stall_left       = 0;
    int items_sent       = 0;
    int settings_applied = 0;
    bit quiet            = 1'b0;

    cascaded_byte_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .slot      (slot),
        .byte_in   (byte_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_out  (byte_out),
        .last_out  (last_out),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    // Mostly zero, sometimes short, now and then a long hold.
    // A quiet stretch turns idling off on both channels.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Sample all three channels at the edge; every DUT and bench signal
    // still holds its pre-edge value here.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_result(byte_out, last_out, overflow);
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_input(mode, slot, byte_in, last_in);
        end
    end

    // Receiver: take one beat, then maybe stall for a random stretch.
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            stall_left = idle_gap();
        end
    end

    // Present one beat and hold it until accepted. Valid stays high when the
    // next beat follows with no gap, so it is never dropped and raised in the
    // same step.
    task automatic send_beat(input logic [1:0] m, input logic [5:0] s,
                             input logic [7:0] b, input logic l);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        slot     <= s;
        byte_in  <= b;
        last_in  <= l;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Hold the input side until every expected beat has come out.
    // The wait comes before the check, so valid is not toggled twice in a step.
    task automatic hold_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_beats.size() != 0);
    endtask

    // Drain, then let any beat that causes no result finish inside the block.
    task automatic settle();
        hold_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [6:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Flag registers look at bit 0 only; fill the rest with noise.
    function automatic logic [6:0] flag_word(input bit f);
        return {6'($urandom_range(0, 63)), f};
    endfunction

    task automatic apply_settings(input bit rev, input bit rot, input bit sub,
                                  input bit xr, input logic [6:0] amt,
                                  input logic [6:0] klen);
        settle();
        write_reg(CFG_REVERSE, flag_word(rev));
        write_reg(CFG_ROTATE, flag_word(rot));
        write_reg(CFG_SUBSTITUTE, flag_word(sub));
        write_reg(CFG_XOR, flag_word(xr));
        write_reg(CFG_ROT_AMOUNT, amt);
        write_reg(CFG_KEY_LENGTH, klen);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic change_reg(input logic [CFG_AW-1:0] idx, input logic [6:0] d);
        settle();
        write_reg(idx, d);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [7:0] pick_letter();
        int idx;
        idx = $urandom_range(0, TBL_DEPTH - 1);
        return (idx < CASE_LEN) ? 8'(LOWER_A + idx) : 8'(UPPER_A + idx - CASE_LEN);
    endfunction

    // Letters, codes at the edges of the rotation and letter ranges, or noise.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return pick_letter();
        if (r < 5) begin
            case ($urandom_range(0, 11))
                0:       return 8'd0;
                1:       return ROT_LO - 8'd1;
                2:       return ROT_LO;
                3:       return UPPER_A - 8'd1;
                4:       return UPPER_A;
                5:       return UPPER_Z;
                6:       return UPPER_Z + 8'd1;
                7:       return LOWER_A - 8'd1;
                8:       return LOWER_A;
                9:       return ROT_HI;
                10:      return ROT_HI + 8'd1;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [6:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return 7'd0;
            1:       return ROT_SPAN - 7'd1;
            2:       return ROT_SPAN;
            3:       return 7'd127;
            default: return 7'($urandom_range(1, 126));
        endcase
    endfunction

    function automatic logic [6:0] pick_length();
        case ($urandom_range(0, 6))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'(KEY_DEPTH);
            3:       return 7'(KEY_DEPTH + 1);
            4:       return 7'd127;
            default: return 7'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 96)
            return $urandom_range(9, 24);
        return $urandom_range(56, MSG_DEPTH + 3);
    endfunction

    // Write every key byte and a full letter permutation into the table, so
    // both maps are defined everywhere before any byte is looked up.
    task automatic fill_stores();
        logic [7:0] perm [TBL_DEPTH];
        logic [7:0] t;
        int         j;
        for (int i = 0; i < KEY_DEPTH; i++)
            send_beat(MODE_LOAD_KEY, 6'(i), 8'($urandom_range(0, 255)), 1'($urandom));
        for (int i = 0; i < TBL_DEPTH; i++)
            perm[i] = (i < CASE_LEN) ? 8'(LOWER_A + i) : 8'(UPPER_A + i - CASE_LEN);
        for (int i = TBL_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < TBL_DEPTH; i++)
            send_beat(MODE_LOAD_SUB, 6'(i), perm[i], 1'($urandom));
    endtask

    // Random key or table load between message bytes.
    task automatic send_load();
        logic [5:0] s;
        s = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0) begin
            send_beat(MODE_LOAD_KEY, s, 8'($urandom_range(0, 255)), 1'($urandom));
        end
        else begin
            send_beat(MODE_LOAD_SUB, s,
                      ($urandom_range(0, 9) < 7) ? pick_letter() : 8'($urandom_range(0, 255)),
                      1'($urandom));
        end
    endtask

    // One message in a single direction, with the odd byte flipped and loads
    // slipped in between bytes.
    task automatic send_message(input int len);
        logic [1:0] dir, flip;
        dir  = $urandom_range(0, 1) ? MODE_DECIPHER : MODE_ENCIPHER;
        flip = (dir == MODE_DECIPHER) ? MODE_ENCIPHER : MODE_DECIPHER;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_load();
            send_beat(($urandom_range(0, 6) == 0) ? flip : dir,
                      6'($urandom_range(0, 63)), pick_byte(), i == len - 1);
        end
    endtask

    initial
    begin
        int phase;
        int msgs;
        int waited;

        // Hold reset low, then release it once.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_stores();

        // Every step off: bytes pass through untouched.
        apply_settings(1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 7'd0);
        send_beat(MODE_ENCIPHER, 6'd0, 8'd0, 1'b0);
        send_beat(MODE_DECIPHER, 6'd63, 8'd255, 1'b1);

        // Rotation alone at the borders of its range, longest legal distance.
        apply_settings(1'b0, 1'b1, 1'b0, 1'b0, ROT_SPAN - 7'd1, 7'd0);
        send_beat(MODE_ENCIPHER, 6'd0, ROT_LO - 8'd1, 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, ROT_LO, 1'b0);
        send_beat(MODE_DECIPHER, 6'd0, ROT_HI, 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, ROT_HI + 8'd1, 1'b1);

        // Full cascade; a distance of one whole span folds to no rotation,
        // and the key uses the whole store.
        apply_settings(1'b0, 1'b1, 1'b1, 1'b1, ROT_SPAN, 7'(KEY_DEPTH));
        send_beat(MODE_ENCIPHER, 6'd0, LOWER_A, 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, LOWER_Z, 1'b0);
        send_beat(MODE_DECIPHER, 6'd0, UPPER_A, 1'b0);
        send_beat(MODE_DECIPHER, 6'd0, UPPER_Z, 1'b0);
        send_beat(MODE_DECIPHER, 6'd0, LOWER_A - 8'd1, 1'b1);

        // Loads at the store edges: top key slot, last letter slot, a table
        // entry that maps a letter to a non-letter, and an out-of-range slot.
        send_beat(MODE_LOAD_KEY, 6'd63, 8'($urandom_range(0, 255)), 1'b1);
        send_beat(MODE_LOAD_SUB, 6'(TBL_DEPTH - 1), LOWER_A + 8'd16, 1'b0);
        send_beat(MODE_LOAD_SUB, 6'd0, 8'h23, 1'b0);
        send_beat(MODE_LOAD_SUB, 6'(TBL_DEPTH), UPPER_A, 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, LOWER_A, 1'b1);

        // Key length past the store depth saturates; zero key length skips XOR.
        apply_settings(1'b0, 1'b0, 1'b0, 1'b1, 7'd127, 7'd127);
        send_beat(MODE_ENCIPHER, 6'd0, 8'd255, 1'b1);
        change_reg(CFG_KEY_LENGTH, 7'd0);
        send_beat(MODE_DECIPHER, 6'd0, 8'd0, 1'b1);

        // Shrink the key between bytes of one message: the position wraps.
        apply_settings(1'b0, 1'b0, 1'b0, 1'b1, 7'd0, 7'd5);
        send_beat(MODE_ENCIPHER, 6'd0, pick_byte(), 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, pick_byte(), 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, pick_byte(), 1'b0);
        change_reg(CFG_KEY_LENGTH, 7'd2);
        send_beat(MODE_ENCIPHER, 6'd0, pick_byte(), 1'b1);

        // Reversal: the last byte decides the direction of the whole message.
        apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 7'd5, 7'd3);
        send_beat(MODE_ENCIPHER, 6'd0, pick_letter(), 1'b0);
        send_beat(MODE_ENCIPHER, 6'd0, pick_letter(), 1'b0);
        send_beat(MODE_DECIPHER, 6'd0, pick_letter(), 1'b1);

        // Turn reversal off halfway: the buffered bytes are thrown away.
        send_beat(MODE_ENCIPHER, 6'd0, pick_byte(), 1'b0);
        change_reg(CFG_REVERSE, flag_word(1'b0));
        send_beat(MODE_DECIPHER, 6'd0, pick_byte(), 1'b1);

        // Writes to the two unused indexes must not disturb anything.
        settle();
        write_reg(CFG_SPARE_A, 7'($urandom_range(0, 127)));
        write_reg(CFG_SPARE_B, 7'($urandom_range(0, 127)));
        cfg_valid <= 1'b0;

        // Random phases until the item budget is spent. The first keeps
        // reversal on and overruns the buffer once; any later phase draws
        // every setting at random.
        phase = 0;
        while (items_sent < ITEM_TARGET || phase == 0) begin
            apply_settings((phase == 0) || ($urandom_range(0, 9) < 4),
                           1'($urandom), 1'($urandom), 1'($urandom),
                           pick_amount(), pick_length());
            quiet = (phase != 0) && ($urandom_range(0, 3) == 0);
            msgs  = $urandom_range(2, 5);
            for (int m = 0; m < msgs; m++) begin
                send_message((phase == 0 && m == 0)
                             ? $urandom_range(MSG_DEPTH + 1, MSG_DEPTH + 3)
                             : pick_msg_len());
                // Pause the sender until the block has emptied out.
                if (m == 0 && (phase == 0 || $urandom_range(0, 3) == 0))
                    hold_for_drain();
            end
            phase++;
        end
        quiet = 1'b0;

        // Drop valid and wait out every outstanding result, then a little more
        // to catch stray beats.
        in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (sb.expected_beats.size() != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_beats.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_beats.size());
            sb.errors++;
        end

        $display("covered %0d input items, %0d random phases, %0d register settings, %0d messages",
                 items_sent, phase, settings_applied, sb.messages_closed);
        $display("checked %0d output beats, %0d of them flagged with dropped bytes, %0d errors",
                 sb.beats_checked, sb.lossy_beats, sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
